// ===== sv/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_UNITS  = 4096;
    localparam int AW          = $clog2(HEAP_UNITS);
    localparam int IW          = AW + 1;
    localparam int CW          = $clog2(3 * HEAP_UNITS + 10);
    localparam logic [IW-1:0] SENT       = IW'(HEAP_UNITS);
    localparam logic [CW-1:0] WALK_LIMIT = CW'(3 * HEAP_UNITS + 8);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_START,
        S_A_LINK0,
        S_A_CHK,
        S_A_SPLIT,
        S_GROW,
        S_I_START,
        S_I_WALK,
        S_I_RDQ,
        S_I_RDB,
        S_I_WP,
        S_OUT
    } t_state;

endpackage

// ===== sv/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/first_fit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit allocator over a circular, address-ordered free list of heap
// blocks; block headers live in two RAMs (link and size).
// ----------------------------------------------------------------------------
//  channel  dir  signals                         content
//  s        in   i_s_tvalid/o_s_tready           tuser: action
//                                                tdata: request_bytes, block_addr
//  m        out  o_m_tvalid/i_m_tready           tuser: failed
//                                                tdata: result_addr
//  cfg      in   i_cfg_valid/o_cfg_ready         data: heap_units
//
//  Requests walk the free list one block per cycle through the RAM read port.
//  Allocate checks one block after another; a split adds a second size write.
//  Free walks to the insert point, then merges; an ignored free skips that;
//  each bump growth inside an allocate adds such an insert plus its own walk.
//  Reset is synchronous; no RAM clearing pass is needed.
//  A request is taken only in idle; a result waits in the output register.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] request_bytes, [27:16] block_addr
    input  logic        i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [11:0] result_addr
    output logic        o_m_tuser,   // [0] failed
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // [12:0] heap_units
);
    import ffa_pkg::*;

    t_state r_state, n_state;
    logic [IW-1:0] r_nu, n_nu, r_prev, n_prev, r_p, n_p, r_q, n_q, r_bp, n_bp;
    logic [IW-1:0] r_psize, n_psize, r_qsize, n_qsize, r_qlink, n_qlink;
    logic [IW-1:0] r_bsize, n_bsize, r_blink, n_blink;
    logic [IW-1:0] r_rover, n_rover, r_slink, n_slink, r_bump, n_bump, r_heap;
    logic          r_started, n_started, r_grow, n_grow, r_rd_sent;
    logic [CW-1:0] r_na, n_na, r_ni, n_ni;
    logic [AW-1:0] r_res, n_res;
    logic          r_fail, n_fail;
    logic          r_ovalid;
    logic [AW-1:0] r_oaddr;
    logic          r_ofail;

    logic          rd_en, wl_en, ws_en;
    logic [IW-1:0] rd_addr, w_addr, wl_data, ws_data;
    logic [IW-1:0] link_q, size_q, rd_link, rd_size;
    logic [IW-1:0] limit;
    logic [IW:0]   nu_sum, sum_a, sum_b;
    logic [16:0]   bytes_up;
    logic          brk, merge;

    ffa_ram #(.WIDTH(IW), .DEPTH(HEAP_UNITS)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (wl_en && !w_addr[AW]),
        .i_waddr(w_addr[AW-1:0]),
        .i_wdata(wl_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr[AW-1:0]),
        .o_rdata(link_q)
    );

    ffa_ram #(.WIDTH(IW), .DEPTH(HEAP_UNITS)) u_size_ram (
        .i_clk  (i_clk),
        .i_we   (ws_en && !w_addr[AW]),
        .i_waddr(w_addr[AW-1:0]),
        .i_wdata(ws_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr[AW-1:0]),
        .o_rdata(size_q)
    );

    assign rd_link  = r_rd_sent ? r_slink : ((link_q >= SENT) ? SENT : link_q);
    assign rd_size  = r_rd_sent ? '0 : size_q;
    assign limit    = (r_heap < SENT) ? r_heap : SENT;
    assign bytes_up = {1'b0, i_s_tdata[15:0]} + 17'd15;

    always_comb begin
        n_state = r_state;   n_nu = r_nu;       n_prev = r_prev;   n_p = r_p;
        n_q = r_q;           n_bp = r_bp;       n_psize = r_psize; n_qsize = r_qsize;
        n_qlink = r_qlink;   n_bsize = r_bsize; n_blink = r_blink; n_rover = r_rover;
        n_slink = r_slink;   n_bump = r_bump;   n_started = r_started;
        n_grow = r_grow;     n_na = r_na;       n_ni = r_ni;
        n_res = r_res;       n_fail = r_fail;
        rd_en = 1'b0;  rd_addr = r_p;
        wl_en = 1'b0;  ws_en = 1'b0;  w_addr = r_p;  wl_data = '0;  ws_data = '0;
        nu_sum = '0;   sum_a = '0;    sum_b = '0;
        brk = 1'b0;    merge = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_res  = '0;
                    n_fail = 1'b0;
                    if (i_s_tuser == ACT_ALLOC) begin
                        n_nu = IW'(bytes_up[16:4]) + IW'(1);
                        n_na = '0;
                        if (!r_started) begin
                            n_slink   = SENT;
                            n_rover   = SENT;
                            n_started = 1'b1;
                        end
                        n_state = S_A_START;
                    end else if (r_started && i_s_tdata[27:16] != '0) begin
                        n_bp    = IW'(i_s_tdata[27:16]) - IW'(1);
                        n_grow  = 1'b0;
                        n_ni    = '0;
                        n_state = S_I_START;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_A_START: begin
                n_prev  = r_rover;
                rd_en   = 1'b1;
                rd_addr = r_rover;
                n_state = S_A_LINK0;
            end
            S_A_LINK0: begin
                n_p     = rd_link;
                rd_en   = 1'b1;
                rd_addr = rd_link;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (rd_size >= r_nu) begin
                    n_rover = r_prev;
                    if (rd_size == r_nu) begin
                        wl_en   = 1'b1;
                        w_addr  = r_prev;
                        wl_data = rd_link;
                        n_res   = r_p[AW-1:0] + AW'(1);
                        n_state = S_OUT;
                    end else begin
                        ws_en   = 1'b1;
                        w_addr  = r_p;
                        ws_data = rd_size - r_nu;
                        n_p     = r_p + (rd_size - r_nu);
                        n_state = S_A_SPLIT;
                    end
                end else if (r_p == r_rover) begin
                    n_state = S_GROW;
                end else if (r_na + CW'(1) > WALK_LIMIT) begin
                    n_fail  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_na    = r_na + CW'(1);
                    n_prev  = r_p;
                    n_p     = rd_link;
                    rd_en   = 1'b1;
                    rd_addr = rd_link;
                end
            end
            S_A_SPLIT: begin
                ws_en   = 1'b1;
                w_addr  = r_p;
                ws_data = r_nu;
                n_res   = r_p[AW-1:0] + AW'(1);
                n_state = S_OUT;
            end
            S_GROW: begin
                nu_sum = {1'b0, r_bump} + {1'b0, r_nu};
                if (nu_sum >= {1'b0, limit}) begin
                    n_fail  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_bump  = nu_sum[IW-1:0];
                    ws_en   = 1'b1;
                    w_addr  = r_bump;
                    ws_data = r_nu;
                    n_bp    = r_bump;
                    n_grow  = 1'b1;
                    n_ni    = '0;
                    n_state = S_I_START;
                end
            end
            S_I_START: begin
                n_p     = r_rover;
                rd_en   = 1'b1;
                rd_addr = r_rover;
                n_state = S_I_WALK;
            end
            S_I_WALK: begin
                brk = (r_bp > r_p && r_bp < rd_link) ||
                      (r_p >= rd_link && (r_bp > r_p || r_bp < rd_link));
                rd_en   = 1'b1;
                rd_addr = rd_link;
                if (brk) begin
                    n_q     = rd_link;
                    n_psize = rd_size;
                    n_state = S_I_RDQ;
                end else if (r_ni + CW'(1) > WALK_LIMIT) begin
                    rd_en   = 1'b0;
                    n_fail  = r_grow;
                    n_state = S_OUT;
                end else begin
                    n_ni = r_ni + CW'(1);
                    n_p  = rd_link;
                end
            end
            S_I_RDQ: begin
                n_qsize = rd_size;
                n_qlink = rd_link;
                rd_en   = 1'b1;
                rd_addr = r_bp;
                n_state = S_I_RDB;
            end
            S_I_RDB: begin
                sum_a = {1'b0, r_bp} + {1'b0, rd_size};
                merge = (r_q != SENT) && (sum_a == {1'b0, r_q});
                n_bsize = merge ? (rd_size + r_qsize) : rd_size;
                n_blink = merge ? r_qlink : r_q;
                wl_en   = 1'b1;
                ws_en   = 1'b1;
                w_addr  = r_bp;
                wl_data = n_blink;
                ws_data = n_bsize;
                n_state = S_I_WP;
            end
            S_I_WP: begin
                sum_b = {1'b0, r_p} + {1'b0, r_psize};
                merge = (r_p != SENT) && (sum_b == {1'b0, r_bp});
                wl_en  = 1'b1;
                w_addr = r_p;
                if (merge) begin
                    ws_en   = 1'b1;
                    ws_data = r_psize + r_bsize;
                    wl_data = r_blink;
                end else begin
                    wl_data = r_bp;
                end
                if (r_p == SENT) begin
                    n_slink = merge ? r_blink : r_bp;
                end
                n_rover = r_p;
                if (!r_grow) begin
                    n_state = S_OUT;
                end else if (r_na + CW'(1) > WALK_LIMIT) begin
                    n_fail  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_na    = r_na + CW'(1);
                    n_state = S_A_START;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (wl_en && w_addr == SENT) begin
            n_slink = wl_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rover   <= SENT;
            r_slink   <= SENT;
            r_started <= 1'b0;
            r_bump    <= '0;
            r_heap    <= IW'(HEAP_UNITS);
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rover   <= n_rover;
            r_slink   <= n_slink;
            r_started <= n_started;
            r_bump    <= n_bump;
            if (i_cfg_valid) begin
                r_heap <= i_cfg_data[IW-1:0];
            end
            if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nu      <= n_nu;
        r_prev    <= n_prev;
        r_p       <= n_p;
        r_q       <= n_q;
        r_bp      <= n_bp;
        r_psize   <= n_psize;
        r_qsize   <= n_qsize;
        r_qlink   <= n_qlink;
        r_bsize   <= n_bsize;
        r_blink   <= n_blink;
        r_grow    <= n_grow;
        r_na      <= n_na;
        r_ni      <= n_ni;
        r_res     <= n_res;
        r_fail    <= n_fail;
        if (rd_en) begin
            r_rd_sent <= rd_addr[AW];
        end
        if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
            r_oaddr <= r_res;
            r_ofail <= r_fail;
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {{(16 - AW){1'b0}}, r_oaddr};
    assign o_m_tuser   = r_ofail;

endmodule

// ===== test/tb_first_fit_free_list_allocator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator_unit
// Self-checking bench for the first-fit allocator. A queue of allocate and
// free requests, built alongside a behavioral copy of the free list, feeds a
// clocked driver; a clocked monitor compares each result transfer with the
// oldest predicted one. Random frees name only blocks still held. The heap
// size register is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator_unit;
    import ffa_pkg::*;

    localparam int unsigned NUNITS = 4096;
    localparam int unsigned WLIM   = 3 * NUNITS + 8;
    localparam int          WDOG   = 100000;

    typedef struct {
        logic        act;
        logic [15:0] bytes;
        logic [11:0] addr;
    } t_req;

    typedef struct {
        logic [11:0] addr;
        logic        failed;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [15:0] request_bytes, [27:16] block_addr
    logic        i_s_tuser = 1'b0; // [0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // [11:0] result_addr
    logic        o_m_tuser;        // [0] failed
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;  // [12:0] heap_units

    first_fit_free_list_allocator_unit uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // behavioral free list
    int unsigned hdr_link[NUNITS];
    int unsigned hdr_size[NUNITS];
    int unsigned sent_link = NUNITS;
    int unsigned rover_p   = NUNITS;
    bit          started   = 1'b0;
    int unsigned bump      = 0;
    int unsigned heap_cfg  = 4096;
    int unsigned held[$];

    t_req  pending_reqs[$];
    t_res  expected_results[$];
    bit    failed_any = 1'b0;
    int    results_seen = 0;

    function automatic int unsigned clip(int unsigned i);
        return (i >= NUNITS) ? NUNITS : i;
    endfunction

    function automatic int unsigned link_of(int unsigned i);
        return (i >= NUNITS) ? clip(sent_link) : clip(hdr_link[i]);
    endfunction

    function automatic int unsigned size_of(int unsigned i);
        return (i >= NUNITS) ? 0 : hdr_size[i];
    endfunction

    function automatic void put_link(int unsigned i, int unsigned v);
        if (i >= NUNITS) sent_link = clip(v);
        else hdr_link[i] = clip(v);
    endfunction

    function automatic void put_size(int unsigned i, int unsigned v);
        if (i < NUNITS) hdr_size[i] = v;
    endfunction

    function automatic bit link_in(int unsigned bp);
        int unsigned p;
        int unsigned q;
        int unsigned n;
        p = clip(rover_p);
        n = 0;
        forever begin
            q = link_of(p);
            if (bp > p && bp < q) break;
            if (p >= q && (bp > p || bp < q)) break;
            p = q;
            n++;
            if (n > WLIM) return 1'b0;
        end
        if (q != NUNITS && bp + size_of(bp) == q) begin
            put_size(bp, size_of(bp) + size_of(q));
            put_link(bp, link_of(q));
        end else begin
            put_link(bp, q);
        end
        if (p != NUNITS && p + size_of(p) == bp) begin
            put_size(p, size_of(p) + size_of(bp));
            put_link(p, link_of(bp));
        end else begin
            put_link(p, bp);
        end
        rover_p = p;
        return 1'b1;
    endfunction

    function automatic bit bump_grow(int unsigned nu);
        int unsigned lim;
        int unsigned h;
        lim = (heap_cfg < NUNITS) ? heap_cfg : NUNITS;
        h = bump;
        if (h + nu >= lim) return 1'b0;
        bump = h + nu;
        put_size(h, nu);
        return link_in(h);
    endfunction

    function automatic int unsigned first_fit(int unsigned bytes);
        int unsigned nu;
        int unsigned prv;
        int unsigned p;
        int unsigned sz;
        int unsigned n;
        nu = (bytes + 15) / 16 + 1;
        n = 0;
        if (!started) begin
            sent_link = NUNITS;
            rover_p = NUNITS;
            started = 1'b1;
        end
        prv = clip(rover_p);
        p = link_of(prv);
        forever begin
            sz = size_of(p);
            if (sz >= nu) begin
                if (sz == nu) begin
                    put_link(prv, link_of(p));
                end else begin
                    put_size(p, sz - nu);
                    p = p + (sz - nu);
                    put_size(p, nu);
                end
                rover_p = prv;
                return p + 1;
            end
            if (p == clip(rover_p)) begin
                if (!bump_grow(nu)) return 0;
                p = clip(rover_p);
            end
            prv = p;
            p = link_of(p);
            n++;
            if (n > WLIM) return 0;
        end
    endfunction

    task automatic queue_req(logic act, logic [15:0] bytes, logic [11:0] addr);
        t_req r;
        t_res e;
        int unsigned a;
        r.act = act;
        r.bytes = bytes;
        r.addr = addr;
        e.addr = '0;
        e.failed = 1'b0;
        if (act == ACT_ALLOC) begin
            a = first_fit(bytes);
            e.addr = a[11:0];
            e.failed = (a == 0);
            if (a != 0) held.push_back(a);
        end else if (started && addr != 0) begin
            void'(link_in(addr - 1));
        end
        pending_reqs.push_back(r);
        expected_results.push_back(e);
    endtask

    task automatic free_held(int unsigned idx);
        int unsigned a;
        a = held[idx];
        held.delete(idx);
        queue_req(ACT_FREE, 16'($urandom), a[11:0]);
    endtask

    task automatic random_reqs(int count);
        int unsigned b;
        for (int k = 0; k < count; k++) begin
            if (held.size() > 0 && $urandom_range(99) < 45) begin
                free_held($urandom_range(held.size() - 1));
            end else begin
                case ($urandom_range(19))
                    0:       b = $urandom_range(65535);
                    1, 2:    b = 16 * $urandom_range(12);
                    3:       b = $urandom_range(1500);
                    default: b = $urandom_range(200);
                endcase
                queue_req(ACT_ALLOC, b[15:0], 12'($urandom));
            end
        end
    endtask

    task automatic settle();
        while (pending_reqs.size() > 0 || i_s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_heap(int unsigned v);
        heap_cfg = v & 16'h1FFF;
        @(posedge i_clk);
        i_cfg_data <= 16'(v);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // request driver
    int  tx_gap = 0;
    bit  tx_busy = 1'b0;
    t_req cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            i_s_tvalid <= 1'b0;
            tx_gap = tx_busy ? 0 : $urandom_range(8);
            if ($urandom_range(99) == 0) tx_busy = !tx_busy;
        end else if (!i_s_tvalid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_reqs.size() > 0) begin
                cur = pending_reqs.pop_front();
                i_s_tuser <= cur.act;
                i_s_tdata <= {4'b0, cur.addr, cur.bytes};
                i_s_tvalid <= 1'b1;
            end
        end
    end

    // result monitor
    int  rx_gap = 0;
    int  rx_hold = 0;
    bit  rx_busy = 1'b0;
    t_res exp_r;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result addr=%0d failed=%0b",
                             $time, o_m_tdata[11:0], o_m_tuser);
                    failed_any = 1'b1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_m_tdata[11:0] !== exp_r.addr) begin
                        $display("%0t: result_addr expected %0d actual %0d",
                                 $time, exp_r.addr, o_m_tdata[11:0]);
                        failed_any = 1'b1;
                    end
                    if (o_m_tuser !== exp_r.failed) begin
                        $display("%0t: failed expected %0b actual %0b",
                                 $time, exp_r.failed, o_m_tuser);
                        failed_any = 1'b1;
                    end
                end
                rx_gap = rx_busy ? 0 : $urandom_range(8);
                if ($urandom_range(99) == 0) rx_busy = !rx_busy;
                if (results_seen == 150) rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog on transfer activity
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tiny heap
        write_heap(4);
        queue_req(ACT_FREE, 16'h0000, 12'd5);      // free before any allocate
        queue_req(ACT_ALLOC, 16'd0, 12'hFFF);      // header only
        queue_req(ACT_ALLOC, 16'd16, 12'd0);
        queue_req(ACT_ALLOC, 16'd17, 12'd0);       // no room
        queue_req(ACT_FREE, 16'hFFFF, 12'd0);      // address zero ignored
        free_held(0);
        queue_req(ACT_ALLOC, 16'd0, 12'd0);        // exact fit
        settle();

        // full heap
        write_heap(4096);
        queue_req(ACT_ALLOC, 16'hFFFF, 12'd0);     // too large
        queue_req(ACT_ALLOC, 16'd65520, 12'd0);
        queue_req(ACT_ALLOC, 16'd1, 12'd0);
        queue_req(ACT_ALLOC, 16'd32, 12'd0);
        queue_req(ACT_ALLOC, 16'd33, 12'd0);
        queue_req(ACT_ALLOC, 16'd48000, 12'd0);
        queue_req(ACT_ALLOC, 16'd100, 12'd0);
        free_held(held.size() - 2);
        free_held(0);
        free_held(held.size() - 1);
        queue_req(ACT_ALLOC, 16'd15, 12'd0);
        random_reqs(450);
        settle();

        write_heap(300);
        random_reqs(300);
        settle();

        write_heap(4096);
        random_reqs(520);
        settle();

        if (!failed_any && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
